FILE: rtl/core/piecewise_linear_contrast_stretch_defines.svh
// Assertion macros for the contrast stretch block.
`ifndef PIECEWISE_LINEAR_CONTRAST_STRETCH_DEFINES_SVH
`define PIECEWISE_LINEAR_CONTRAST_STRETCH_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define PCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define PCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/pcs_pkg.sv
// Shared types and constants for the contrast stretch block.
package pcs_pkg;

  localparam int CHANNELS   = 3;
  localparam int NUM_FIELDS = 3;
  localparam int PIX_W      = 8;
  localparam int PROD_W     = 2 * PIX_W;
  localparam int DIV_STEPS  = PIX_W;
  // input, segment, product, then one stage per quotient bit
  localparam int NSTG       = DIV_STEPS + 3;
  localparam int CFG_IDX_W  = 3;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CURVE_MODE = 3'd0,
    CFG_KNEE1_IN   = 3'd1,
    CFG_KNEE1_OUT  = 3'd2,
    CFG_KNEE2_IN   = 3'd3,
    CFG_KNEE2_OUT  = 3'd4,
    CFG_KNEE3_IN   = 3'd5,
    CFG_KNEE3_OUT  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic             mode;
    logic [PIX_W-1:0] k1_in;
    logic [PIX_W-1:0] k1_out;
    logic [PIX_W-1:0] k2_in;
    logic [PIX_W-1:0] k2_out;
    logic [PIX_W-1:0] k3_in;
    logic [PIX_W-1:0] k3_out;
  } knee_cfg_t;

  localparam knee_cfg_t CFG_RESET = '{
    mode:   1'b0,
    k1_in:  8'd64,
    k1_out: 8'd64,
    k2_in:  8'd128,
    k2_out: 8'd128,
    k3_in:  8'd192,
    k3_out: 8'd192
  };

  // Segment chosen for one sample: either a direct answer or a slope job
  typedef struct packed {
    logic             direct;
    logic [PIX_W-1:0] dval;
    logic [PIX_W-1:0] y0;
    logic             neg;
    logic [PIX_W-1:0] off;
    logic [PIX_W-1:0] mag;
    logic [PIX_W-1:0] dx;
  } seg_t;

  // Side data that rides along the divider stages
  typedef struct packed {
    logic             direct;
    logic [PIX_W-1:0] dval;
    logic [PIX_W-1:0] y0;
    logic             neg;
    logic [PIX_W-1:0] dx;
  } side_t;

endpackage

FILE: rtl/core/piecewise_linear_contrast_stretch.sv
// Piecewise linear contrast stretch: each channel of a pixel goes through a
// three-knee curve (mode 0) or a clip-and-stretch between two levels (mode 1),
// with truncating slope division and saturation to 0..255. One pixel is taken
// per clock when the output side keeps up; a pixel's result passes through the
// input register, the per-lane pipeline of segment pick, 8x8 multiply and an
// eight-stage bit-per-stage divider, then the output register. Stalls on the
// output only stop the stages that are full, so bubbles are squeezed out. Write
// the knee registers only while no pixel is in flight.
`include "piecewise_linear_contrast_stretch_defines.svh"

module piecewise_linear_contrast_stretch
  import pcs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [PIX_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [PIX_W-1:0]     chan_a_in_i,
  input  logic [PIX_W-1:0]     chan_b_in_i,
  input  logic [PIX_W-1:0]     chan_c_in_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [PIX_W-1:0]     chan_a_out_o,
  output logic [PIX_W-1:0]     chan_b_out_o,
  output logic [PIX_W-1:0]     chan_c_out_o
);

  knee_cfg_t        cfg_q;
  logic [NSTG-1:0]  vld_q;
  logic [NSTG-1:0]  en;
  logic             en_out;
  logic             out_valid_q;
  logic [PIX_W-1:0] chan_in  [NUM_FIELDS];
  logic [PIX_W-1:0] lane_res [NUM_FIELDS];
  logic [PIX_W-1:0] res_q    [NUM_FIELDS];

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_CURVE_MODE: cfg_q.mode   <= cfg_data_i[0];
        CFG_KNEE1_IN:   cfg_q.k1_in  <= cfg_data_i;
        CFG_KNEE1_OUT:  cfg_q.k1_out <= cfg_data_i;
        CFG_KNEE2_IN:   cfg_q.k2_in  <= cfg_data_i;
        CFG_KNEE2_OUT:  cfg_q.k2_out <= cfg_data_i;
        CFG_KNEE3_IN:   cfg_q.k3_in  <= cfg_data_i;
        CFG_KNEE3_OUT:  cfg_q.k3_out <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage enables: a stage advances when it is empty or its successor advances
  assign en_out = !out_valid_q || out_ready_i;

  always_comb begin
    en[NSTG-1] = !vld_q[NSTG-1] || en_out;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];

  // Advance the valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign chan_in[0] = chan_a_in_i;
  assign chan_in[1] = chan_b_in_i;
  assign chan_in[2] = chan_c_in_i;

  // One lane per channel
  for (genvar i = 0; i < NUM_FIELDS; i++) begin : g_lane
    if (i < CHANNELS) begin : g_on
      pcs_lane u_lane (
        .clk_i (clk_i),
        .en_i  (en),
        .cfg_i (cfg_q),
        .v_i   (chan_in[i]),
        .res_o (lane_res[i])
      );
    end else begin : g_off
      assign lane_res[i] = '0;
    end
  end

  // Merge lane results into the output beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_out) begin
      out_valid_q <= vld_q[NSTG-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      for (int i = 0; i < NUM_FIELDS; i++) begin
        res_q[i] <= lane_res[i];
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign chan_a_out_o = res_q[0];
  assign chan_b_out_o = res_q[1];
  assign chan_c_out_o = res_q[2];

  // Checks on the stage control
  `PCS_ASSERT_NEXT(a_take_fills_first, in_valid_i && in_ready_o, vld_q[0], "accepted beat lost at input stage")
  `PCS_ASSERT_NOW(a_stall_means_full, !in_ready_o, (&vld_q) && out_valid_o && !out_ready_i, "input stalled with a free stage")
  `PCS_ASSERT_NEXT(a_last_holds, vld_q[NSTG-1] && !en[NSTG-1], vld_q[NSTG-1], "last stage dropped a stalled beat")

endmodule

FILE: rtl/core/pcs_seg.sv
// Segment selection for one sample against the knee settings.
module pcs_seg
  import pcs_pkg::*;
(
  input  knee_cfg_t        cfg_i,
  input  logic [PIX_W-1:0] v_i,
  output seg_t             seg_o
);

  logic [PIX_W-1:0] x0, y0, x1, y1;
  logic             use_seg;
  logic [PIX_W:0]   dy;

  // Pick the segment the sample falls in
  always_comb begin
    x0          = '0;
    y0          = '0;
    x1          = '0;
    y1          = '0;
    use_seg     = 1'b0;
    seg_o.dval  = v_i;
    if (!cfg_i.mode) begin
      if (v_i <= cfg_i.k1_in) begin
        if (cfg_i.k1_in == '0) begin
          // zero-width first segment answers its end level
          seg_o.dval = cfg_i.k1_out;
        end else begin
          use_seg = 1'b1;
          x1      = cfg_i.k1_in;
          y1      = cfg_i.k1_out;
        end
      end else if (v_i <= cfg_i.k2_in) begin
        use_seg = 1'b1;
        x0      = cfg_i.k1_in;
        y0      = cfg_i.k1_out;
        x1      = cfg_i.k2_in;
        y1      = cfg_i.k2_out;
      end else if (v_i <= cfg_i.k3_in) begin
        use_seg = 1'b1;
        x0      = cfg_i.k2_in;
        y0      = cfg_i.k2_out;
        x1      = cfg_i.k3_in;
        y1      = cfg_i.k3_out;
      end else begin
        use_seg = 1'b1;
        x0      = cfg_i.k3_in;
        y0      = cfg_i.k3_out;
        x1      = PIX_MAX;
        y1      = PIX_MAX;
      end
    end else begin
      if (v_i <= cfg_i.k1_in) begin
        seg_o.dval = '0;
      end else if (v_i <= cfg_i.k2_in) begin
        use_seg = 1'b1;
        x0      = cfg_i.k1_in;
        x1      = cfg_i.k2_in;
        y1      = PIX_MAX;
      end else begin
        seg_o.dval = PIX_MAX;
      end
    end

    // Slope terms: offset into the segment, rise as sign and magnitude, run
    dy           = {1'b0, y1} - {1'b0, y0};
    seg_o.direct = !use_seg;
    seg_o.y0     = y0;
    seg_o.neg    = dy[PIX_W];
    seg_o.mag    = dy[PIX_W] ? PIX_W'(-dy) : dy[PIX_W-1:0];
    seg_o.off    = v_i - x0;
    seg_o.dx     = x1 - x0;
  end

endmodule

FILE: rtl/core/pcs_lane.sv
// One channel lane: segment pick, multiply, bit-per-stage divide, clamp.
module pcs_lane
  import pcs_pkg::*;
(
  input  logic             clk_i,
  input  logic [NSTG-1:0]  en_i,
  input  knee_cfg_t        cfg_i,
  input  logic [PIX_W-1:0] v_i,
  output logic [PIX_W-1:0] res_o
);

  logic [PIX_W-1:0]  v_q;
  seg_t              seg_d, seg_q;
  logic [PROD_W-1:0] rem_q [DIV_STEPS+1];
  logic [PIX_W-1:0]  quo_q [DIV_STEPS+1];
  side_t             side_q [DIV_STEPS+1];
  logic signed [PIX_W+1:0] sum;

  // Capture the sample
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      v_q <= v_i;
    end
  end

  pcs_seg u_seg (
    .cfg_i (cfg_i),
    .v_i   (v_q),
    .seg_o (seg_d)
  );

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      seg_q <= seg_d;
    end
  end

  // Multiply offset by rise magnitude
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      rem_q[0]         <= seg_q.off * seg_q.mag;
      quo_q[0]         <= '0;
      side_q[0].direct <= seg_q.direct;
      side_q[0].dval   <= seg_q.dval;
      side_q[0].y0     <= seg_q.y0;
      side_q[0].neg    <= seg_q.neg;
      side_q[0].dx     <= seg_q.dx;
    end
  end

  // Restoring divide, one quotient bit per stage, most significant first;
  // the product stays below 256 times the run, so eight bits suffice
  for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
    localparam int K = DIV_STEPS - j;
    logic [PROD_W-1:0] dsh;
    logic              ge;

    assign dsh = PROD_W'(side_q[j-1].dx) << K;
    assign ge  = rem_q[j-1] >= dsh;

    always_ff @(posedge clk_i) begin
      if (en_i[2+j]) begin
        rem_q[j]  <= ge ? (rem_q[j-1] - dsh) : rem_q[j-1];
        quo_q[j]  <= quo_q[j-1] | (PIX_W'(ge) << K);
        side_q[j] <= side_q[j-1];
      end
    end
  end

  // Apply sign, add base level, saturate to the pixel range; a direct answer passes as is
  always_comb begin
    if (side_q[DIV_STEPS].neg) begin
      sum = $signed({2'b00, side_q[DIV_STEPS].y0}) - $signed({2'b00, quo_q[DIV_STEPS]});
    end else begin
      sum = $signed({2'b00, side_q[DIV_STEPS].y0}) + $signed({2'b00, quo_q[DIV_STEPS]});
    end
    if (side_q[DIV_STEPS].direct) begin
      res_o = side_q[DIV_STEPS].dval;
    end else if (sum < 0) begin
      res_o = '0;
    end else if (sum > $signed({2'b00, PIX_MAX})) begin
      res_o = PIX_MAX;
    end else begin
      res_o = sum[PIX_W-1:0];
    end
  end

endmodule
